// ===== sv/sliding_mode_joint_compensator_defines.svh =====
// ----------------------------------------------------------------------------
// Sliding-mode joint compensator: assertion macros
// Concurrent checks clocked on clk and held off while rst_n is low. They
// expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SLIDING_MODE_JOINT_COMPENSATOR_DEFINES_SVH
`define SLIDING_MODE_JOINT_COMPENSATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define SMJC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SMJC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SMJC_ASSERT_IMPLY(lbl, ante, cons, msg)
`define SMJC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/smjc_pkg.sv =====
// ----------------------------------------------------------------------------
// smjc_pkg
// Widths, scale constants, register map and shared types of the sliding-mode
// joint compensator.
// ----------------------------------------------------------------------------
package smjc_pkg;

  localparam int NUM_JOINTS      = 12;
  localparam int JOINTS_PER_GAIN = 6;
  localparam int JOINTS_PER_BETA = 4;

  localparam int JOINT_W  = 4;
  localparam int ERR_W    = 24;
  localparam int COMP_W   = 11;
  localparam int SURF_W   = 30;
  localparam int GAIN_W   = 10;
  localparam int LAMBDA_W = 5;
  localparam int BETA_W   = 16;
  localparam int KVEL_W   = 20;
  localparam int KPOS_W   = 16;

  localparam int LK_W     = LAMBDA_W + KPOS_W;
  localparam int PV_W     = ERR_W + KVEL_W + 1;
  localparam int PP_W     = ERR_W + LK_W + 1;
  localparam int ACC_W    = PP_W + 1;
  localparam int SURF_LSB = 16;
  localparam int NUM_W    = GAIN_W + BETA_W;

  localparam int ENABLE_W   = NUM_JOINTS;
  localparam int PACK_W     = 60;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int BETA_REGS  = 3;

  // velocity scale 60*34/(2*pi*160*50) in Q16 with the Q8 input folded in
  localparam logic [KVEL_W-1:0]        KVEL   = 20'd680895;
  localparam logic signed [KVEL_W:0]   KVEL_S = {1'b0, KVEL};
  // floor(2^32 / D) for joint 0 and for the other joints
  localparam logic [KPOS_W-1:0]        KPOS_J0 = 16'd57345;
  localparam logic [KPOS_W-1:0]        KPOS_JN = 16'd54815;
  localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (SURF_LSB - 1);

  localparam logic [ENABLE_W-1:0]   ENABLE_RST = 12'd4030;
  localparam logic [PACK_W-1:0]     GAIN_RST   = 60'd338100147978547200;
  localparam logic [PACK_W-1:0]     LAMBDA_RST = 60'd371910152038984000;
  localparam logic [CFG_DATA_W-1:0] BETA0_RST  = 64'd553385435001192448;
  localparam logic [CFG_DATA_W-1:0] BETA1_RST  = 64'd369013694553589023;
  localparam logic [CFG_DATA_W-1:0] BETA2_RST  = 64'd369019325298640159;

  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = GAIN_W / DIV_STEP;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE   = 3'd0,
    REG_GAIN_LO  = 3'd1,
    REG_GAIN_HI  = 3'd2,
    REG_LAMBDA   = 3'd3,
    REG_BETA_LO  = 3'd4,
    REG_BETA_MID = 3'd5,
    REG_BETA_HI  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [BETA_W-1:0] beta;
    logic              active;
  } smjc_jcfg_t;

  typedef struct packed {
    logic signed [SURF_W-1:0] surface;
    logic                     clip;
    logic                     neg;
    logic                     active;
    logic [GAIN_W-1:0]        gain;
  } smjc_side_t;

endpackage

// ===== sv/smjc_ifs.sv =====
// ----------------------------------------------------------------------------
// smjc channel interfaces
// Sample input, result output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface smjc_in_if import smjc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [JOINT_W-1:0]      joint_index;
  logic signed [ERR_W-1:0] velocity_error;
  logic signed [ERR_W-1:0] position_error;

  modport source (output valid, joint_index, velocity_error, position_error, input ready);
  modport sink (input valid, joint_index, velocity_error, position_error, output ready);
endinterface

interface smjc_out_if import smjc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] compensation;
  logic signed [SURF_W-1:0] surface_value;
  logic                     saturated;

  modport source (output valid, compensation, surface_value, saturated, input ready);
  modport sink (input valid, compensation, surface_value, saturated, output ready);
endinterface

interface smjc_cfg_if import smjc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/smjc_div.sv =====
// ----------------------------------------------------------------------------
// smjc_div
// Pipelined restoring divider, two quotient bits per stage. Quotient must fit
// GAIN_W bits (numerator below divisor * 2^GAIN_W). Side data rides along.
// ----------------------------------------------------------------------------
module smjc_div import smjc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [BETA_W-1:0] in_den,
  input  smjc_side_t        in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [GAIN_W-1:0] out_quot,
  output smjc_side_t        out_side
);

  logic [DIV_STAGES-1:0] v_r;
  logic [DIV_STAGES-1:0] v_nxt;
  logic [DIV_STAGES-1:0] en;
  logic [BETA_W-1:0]     rem_r   [DIV_STAGES];
  logic [BETA_W-1:0]     rem_nxt [DIV_STAGES];
  logic [GAIN_W-1:0]     bits_r  [DIV_STAGES];
  logic [GAIN_W-1:0]     bits_nxt[DIV_STAGES];
  logic [GAIN_W-1:0]     quot_r  [DIV_STAGES];
  logic [GAIN_W-1:0]     quot_nxt[DIV_STAGES];
  logic [BETA_W-1:0]     den_r   [DIV_STAGES];
  logic [BETA_W-1:0]     den_nxt [DIV_STAGES];
  smjc_side_t            side_r  [DIV_STAGES];
  smjc_side_t            side_nxt[DIV_STAGES];

  function automatic logic [BETA_W:0] div_step(logic [BETA_W-1:0] rem, logic bit_in,
                                                logic [BETA_W-1:0] den);
    logic [BETA_W:0] trial;
    logic [BETA_W:0] diff;
    trial = {rem, bit_in};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      return {1'b1, diff[BETA_W-1:0]};
    end
    return {1'b0, trial[BETA_W-1:0]};
  endfunction

  // a stage takes a word when it is empty or its word moves on
  always_comb begin
    en[DIV_STAGES-1] = !v_r[DIV_STAGES-1] || out_ready;
    for (int k = DIV_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    logic [BETA_W-1:0] r;
    logic [GAIN_W-1:0] b;
    logic [GAIN_W-1:0] q;
    logic [BETA_W-1:0] d;
    logic [BETA_W:0]   st;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        v_nxt[k]    = in_valid;
        r           = in_num[NUM_W-1:GAIN_W];
        b           = in_num[GAIN_W-1:0];
        q           = '0;
        d           = in_den;
        side_nxt[k] = in_side;
      end else begin
        v_nxt[k]    = v_r[k-1];
        r           = rem_r[k-1];
        b           = bits_r[k-1];
        q           = quot_r[k-1];
        d           = den_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      for (int s = 0; s < DIV_STEP; s++) begin
        st = div_step(r, b[GAIN_W-1], d);
        r  = st[BETA_W-1:0];
        q  = {q[GAIN_W-2:0], st[BETA_W]};
        b  = {b[GAIN_W-2:0], 1'b0};
      end
      rem_nxt[k]  = r;
      bits_nxt[k] = b;
      quot_nxt[k] = q;
      den_nxt[k]  = d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[k]) begin
        rem_r[k]  <= rem_nxt[k];
        bits_r[k] <= bits_nxt[k];
        quot_r[k] <= quot_nxt[k];
        den_r[k]  <= den_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[DIV_STAGES-1];
  assign out_quot  = quot_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule

// ===== sv/sliding_mode_joint_compensator.sv =====
// ----------------------------------------------------------------------------
// sliding_mode_joint_compensator
// Pipeline: 5 surface and saturation stages, 5 divider stages at two quotient
//   bits each and 1 output register from an accepted sample to its result word.
// Throughput: one sample per cycle while the output word is taken; stages hold
//   independently so bubbles fill while the output word waits.
// Reset: rst_n (synchronous) empties the pipeline and loads the default gains,
//   slopes, boundary widths and enable mask.
// ----------------------------------------------------------------------------
`include "sliding_mode_joint_compensator_defines.svh"

module sliding_mode_joint_compensator import smjc_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  smjc_in_if.sink      in_if,
  smjc_out_if.source   out_if,
  smjc_cfg_if.sink     cfg_if
);

  // configuration registers
  logic [ENABLE_W-1:0]   enable_r;
  logic [PACK_W-1:0]     gain_lo_r;
  logic [PACK_W-1:0]     gain_hi_r;
  logic [PACK_W-1:0]     lambda_r;
  logic [CFG_DATA_W-1:0] beta_r [BETA_REGS];

  logic [LAMBDA_W-1:0] lambda_a [NUM_JOINTS];
  logic [GAIN_W-1:0]   gain_a   [NUM_JOINTS];
  logic [BETA_W-1:0]   beta_a   [NUM_JOINTS];

  // stage 1: joint lookup and lambda * kpos
  logic                    jvalid;
  logic [JOINT_W-1:0]      jsel;
  logic [LAMBDA_W-1:0]     lam;
  logic [KPOS_W-1:0]       kpos;
  logic [LK_W-1:0]         lk1_nxt;
  smjc_jcfg_t              j1_nxt;
  logic                    v1_r;
  logic signed [ERR_W-1:0] vel1_r;
  logic signed [ERR_W-1:0] enc1_r;
  logic [LK_W-1:0]         lk1_r;
  smjc_jcfg_t              j1_r;

  // stage 2: products
  logic                   v2_r;
  logic signed [PV_W-1:0] pv2_r;
  logic signed [PP_W-1:0] pp2_r;
  smjc_jcfg_t             j2_r;

  // stage 3: surface
  logic signed [ACC_W-1:0]  acc;
  logic                     v3_r;
  logic signed [SURF_W-1:0] s3_r;
  smjc_jcfg_t               j3_r;

  // stage 4: magnitude and clip
  logic                     neg;
  logic [SURF_W-1:0]        mag;
  logic                     v4_r;
  logic signed [SURF_W-1:0] s4_r;
  logic [BETA_W-1:0]        mag4_r;
  logic                     clip4_r;
  logic                     neg4_r;
  smjc_jcfg_t               j4_r;

  // stage 5: gain * |s|
  logic              v5_r;
  logic [NUM_W-1:0]  num5_r;
  logic [BETA_W-1:0] den5_r;
  smjc_side_t        side5_r;

  logic              en1, en2, en3, en4, en5, en_out;
  logic              div_in_ready;
  logic              div_out_valid;
  logic [GAIN_W-1:0] div_quot;
  smjc_side_t        div_side;

  // output register
  logic [GAIN_W-1:0]        comp_mag;
  logic signed [COMP_W-1:0] comp_ext;
  logic signed [COMP_W-1:0] comp_nxt;
  logic                     out_valid_r;
  logic signed [COMP_W-1:0] out_comp_r;
  logic signed [SURF_W-1:0] out_surf_r;
  logic                     out_sat_r;

  // --------------------------------------------------------------------------
  // register writes
  // --------------------------------------------------------------------------
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= ENABLE_RST;
      gain_lo_r <= GAIN_RST;
      gain_hi_r <= GAIN_RST;
      lambda_r  <= LAMBDA_RST;
      beta_r[0] <= BETA0_RST;
      beta_r[1] <= BETA1_RST;
      beta_r[2] <= BETA2_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_reg_e'(cfg_if.index))
        REG_ENABLE:   enable_r  <= cfg_if.data[ENABLE_W-1:0];
        REG_GAIN_LO:  gain_lo_r <= cfg_if.data[PACK_W-1:0];
        REG_GAIN_HI:  gain_hi_r <= cfg_if.data[PACK_W-1:0];
        REG_LAMBDA:   lambda_r  <= cfg_if.data[PACK_W-1:0];
        REG_BETA_LO:  beta_r[0] <= cfg_if.data;
        REG_BETA_MID: beta_r[1] <= cfg_if.data;
        REG_BETA_HI:  beta_r[2] <= cfg_if.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_JOINTS; j++) begin
      lambda_a[j] = lambda_r[LAMBDA_W*j +: LAMBDA_W];
      if (j < JOINTS_PER_GAIN) begin
        gain_a[j] = gain_lo_r[GAIN_W*j +: GAIN_W];
      end else begin
        gain_a[j] = gain_hi_r[GAIN_W*(j-JOINTS_PER_GAIN) +: GAIN_W];
      end
      beta_a[j] = beta_r[j / JOINTS_PER_BETA][BETA_W*(j % JOINTS_PER_BETA) +: BETA_W];
    end
  end

  // --------------------------------------------------------------------------
  // stall chain: each stage refills when empty or when its word moves on
  // --------------------------------------------------------------------------
  assign en_out = !out_valid_r || out_if.ready;
  assign en5    = !v5_r || div_in_ready;
  assign en4    = !v4_r || en5;
  assign en3    = !v3_r || en4;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;

  assign in_if.ready = en1;

  // --------------------------------------------------------------------------
  // stage 1
  // --------------------------------------------------------------------------
  always_comb begin
    jvalid = in_if.joint_index < JOINT_W'(NUM_JOINTS);
    jsel   = jvalid ? in_if.joint_index : '0;
    // joints past the table act as disabled with zero slope
    lam    = jvalid ? lambda_a[jsel] : '0;
    kpos   = (in_if.joint_index == '0) ? KPOS_J0 : KPOS_JN;
    lk1_nxt       = LK_W'(lam) * LK_W'(kpos);
    j1_nxt.gain   = gain_a[jsel];
    j1_nxt.beta   = beta_a[jsel];
    j1_nxt.active = jvalid && enable_r[jsel] && (beta_a[jsel] != '0);
  end

  // --------------------------------------------------------------------------
  // stages 2 to 5
  // --------------------------------------------------------------------------
  always_comb begin
    acc = ACC_W'(pv2_r) + ACC_W'(pp2_r) + ROUND_HALF;
    neg = s3_r[SURF_W-1];
    mag = neg ? SURF_W'(-s3_r) : SURF_W'(s3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_if.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      vel1_r <= in_if.velocity_error;
      enc1_r <= in_if.position_error;
      lk1_r  <= lk1_nxt;
      j1_r   <= j1_nxt;
    end
    if (en2) begin
      pv2_r <= vel1_r * KVEL_S;
      pp2_r <= enc1_r * $signed({1'b0, lk1_r});
      j2_r  <= j1_r;
    end
    if (en3) begin
      s3_r <= acc[SURF_LSB +: SURF_W];
      j3_r <= j2_r;
    end
    if (en4) begin
      s4_r    <= s3_r;
      // low bits suffice: beyond beta the word is clipped and the quotient unused
      mag4_r  <= mag[BETA_W-1:0];
      clip4_r <= mag > SURF_W'(j3_r.beta);
      neg4_r  <= neg;
      j4_r    <= j3_r;
    end
    if (en5) begin
      num5_r          <= NUM_W'(j4_r.gain) * NUM_W'(mag4_r);
      den5_r          <= j4_r.beta;
      side5_r.surface <= s4_r;
      side5_r.clip    <= clip4_r;
      side5_r.neg     <= neg4_r;
      side5_r.active  <= j4_r.active;
      side5_r.gain    <= j4_r.gain;
    end
  end

  // --------------------------------------------------------------------------
  // gain * |s| / beta
  // --------------------------------------------------------------------------
  smjc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v5_r),
    .in_ready  (div_in_ready),
    .in_num    (num5_r),
    .in_den    (den5_r),
    .in_side   (side5_r),
    .out_valid (div_out_valid),
    .out_ready (en_out),
    .out_quot  (div_quot),
    .out_side  (div_side)
  );

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_comb begin
    comp_mag = div_side.clip ? div_side.gain : div_quot;
    comp_ext = $signed(COMP_W'(comp_mag));
    if (!div_side.active) begin
      comp_nxt = '0;
    end else if (div_side.neg) begin
      comp_nxt = -comp_ext;
    end else begin
      comp_nxt = comp_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_comp_r <= comp_nxt;
      out_surf_r <= div_side.surface;
      out_sat_r  <= div_side.active && div_side.clip;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.compensation  = out_comp_r;
  assign out_if.surface_value = out_surf_r;
  assign out_if.saturated     = out_sat_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `SMJC_ASSERT_IMPLY(a_stall_only_when_full, !in_if.ready, v1_r, "input stalled with stage 1 empty")
  `SMJC_ASSERT_IMPLY(a_div_quot_bound, div_out_valid && div_side.active && !div_side.clip, div_quot <= div_side.gain, "quotient above gain inside boundary layer")
  `SMJC_ASSERT_IMPLY(a_sat_sign, out_valid_r && out_sat_r && (out_comp_r != '0), out_comp_r[COMP_W-1] == out_surf_r[SURF_W-1], "clipped command sign differs from surface")
  `SMJC_ASSERT_NEXT(a_out_hold, out_valid_r && !out_if.ready, out_valid_r && $stable(out_comp_r) && $stable(out_surf_r), "stalled result word changed")

endmodule
